@@ src/flc_pkg.sv @@
`timescale 1ns / 1ps

package flc_pkg;

    // default lock count and number of lock fields in the ports
    localparam int NUM_LOCKS_DEF = 4;
    localparam int FIELD_LOCKS   = 4;

    // configuration register widths
    localparam int HOLD_W   = 16;
    localparam int MAXOPN_W = 15;
    localparam int FILT_W   = 8;
    localparam int TIMER_W  = 16;
    localparam int CFG_W    = 16;

    // configuration reset values
    localparam logic [HOLD_W-1:0]   HOLD_TIME_RST = 16'd20;
    localparam logic [MAXOPN_W-1:0] MAX_OPEN_RST  = 15'd300;
    localparam logic [FILT_W-1:0]   FILTER_RST    = 8'd3;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_HOLD_TIME = 2'd0,
        CFG_MAX_OPEN  = 2'd1,
        CFG_FILTER    = 2'd2,
        CFG_NONE      = 2'd3
    } t_cfg_idx;

    // host operation codes
    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_UNLOCK = 2'd1,
        OP_ACK    = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    // lock phases
    typedef enum logic [1:0] {
        PH_IDLE      = 2'd0,
        PH_UNLOCKING = 2'd1,
        PH_OPEN      = 2'd2
    } t_phase;

    // command to one lock lane
    typedef struct packed {
        t_op  op;
        logic sel;
        logic lv;
    } t_lane_cmd;

    // updated status of one lock lane
    typedef struct packed {
        t_phase phase;
        logic   drive;
        logic   pending;
        logic   level;
    } t_lane_stat;

endpackage

@@ src/flc_lock.sv @@
`timescale 1ns / 1ps

module flc_lock (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  flc_pkg::t_lane_cmd                 i_cmd,
    input  logic [flc_pkg::HOLD_W-1:0]         i_hold_time,
    input  logic [flc_pkg::MAXOPN_W-1:0]       i_max_open,
    input  logic [flc_pkg::FILT_W-1:0]         i_filter,
    output flc_pkg::t_lane_stat                o_stat
);

    flc_pkg::t_phase                  r_phase, n_phase;
    logic                             r_armed, n_armed;
    logic [flc_pkg::HOLD_W-1:0]       r_hold, n_hold;
    logic signed [flc_pkg::TIMER_W-1:0] r_timer, n_timer;
    logic                             r_drive, n_drive;
    logic                             r_last, n_last;
    logic [flc_pkg::FILT_W-1:0]       r_cc, n_cc;
    logic                             r_pend, n_pend;
    logic                             r_level, n_level;

    logic [flc_pkg::HOLD_W-1:0]         w_hold_inc;
    logic signed [flc_pkg::TIMER_W-1:0] w_timer_dec;
    logic [flc_pkg::FILT_W-1:0]         w_cc_inc;
    logic                               w_qualify;

    // counter candidates
    assign w_hold_inc  = r_armed ? (r_hold + 16'd1) : r_hold;
    assign w_timer_dec = r_timer - 16'sd1;
    assign w_cc_inc    = r_cc + 8'd1;
    assign w_qualify   = ((r_phase == flc_pkg::PH_UNLOCKING) && !i_cmd.lv) ||
                         ((r_phase == flc_pkg::PH_OPEN) && i_cmd.lv);

    // next state for one item
    always_comb begin
        n_phase = r_phase;
        n_armed = r_armed;
        n_hold  = r_hold;
        n_timer = r_timer;
        n_drive = r_drive;
        n_last  = r_last;
        n_cc    = r_cc;
        n_pend  = r_pend;
        n_level = r_level;
        case (i_cmd.op)
            flc_pkg::OP_TICK: begin
                // phase and confirm counter
                if ((r_phase == flc_pkg::PH_UNLOCKING) || (r_phase == flc_pkg::PH_OPEN)) begin
                    if (w_qualify) begin
                        if (w_hold_inc >= i_hold_time) begin
                            n_armed = 1'b0;
                            n_hold  = '0;
                            n_drive = 1'b0;
                            n_phase = (r_phase == flc_pkg::PH_UNLOCKING) ?
                                      flc_pkg::PH_OPEN : flc_pkg::PH_IDLE;
                        end else begin
                            n_armed = 1'b1;
                            n_hold  = w_hold_inc;
                        end
                    end
                end else begin
                    n_phase = flc_pkg::PH_IDLE;
                    n_armed = 1'b0;
                    n_hold  = '0;
                end
                // open timer, checked after the phase update
                if (n_phase != flc_pkg::PH_IDLE) begin
                    if (w_timer_dec <= 16'sd0) begin
                        n_drive = 1'b0;
                        n_timer = signed'({1'b0, i_max_open});
                    end else begin
                        n_timer = w_timer_dec;
                    end
                end
                // change filter
                if (!r_pend) begin
                    if (r_last != i_cmd.lv) begin
                        if (w_cc_inc >= i_filter) begin
                            n_pend  = 1'b1;
                            n_level = i_cmd.lv;
                            n_cc    = '0;
                            n_last  = i_cmd.lv;
                        end else begin
                            n_cc = w_cc_inc;
                        end
                    end else begin
                        n_cc = '0;
                    end
                end
            end
            flc_pkg::OP_UNLOCK: begin
                if (i_cmd.sel) begin
                    n_phase = flc_pkg::PH_UNLOCKING;
                    n_drive = 1'b1;
                end
            end
            flc_pkg::OP_ACK: begin
                if (i_cmd.sel) begin
                    n_pend = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    // lane state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= flc_pkg::PH_IDLE;
            r_armed <= 1'b0;
            r_hold  <= '0;
            r_timer <= signed'({1'b0, flc_pkg::MAX_OPEN_RST});
            r_drive <= 1'b0;
            r_last  <= 1'b0;
            r_cc    <= '0;
            r_pend  <= 1'b0;
            r_level <= 1'b0;
        end else if (i_en) begin
            r_phase <= n_phase;
            r_armed <= n_armed;
            r_hold  <= n_hold;
            r_timer <= n_timer;
            r_drive <= n_drive;
            r_last  <= n_last;
            r_cc    <= n_cc;
            r_pend  <= n_pend;
            r_level <= n_level;
        end
    end

    // status after this item
    assign o_stat.phase   = n_phase;
    assign o_stat.drive   = n_drive;
    assign o_stat.pending = n_pend;
    assign o_stat.level   = n_level;

endmodule

@@ src/four_lock_unlock_controller.sv @@
`timescale 1ns / 1ps
// channel | valid       | stall        | payload
// --------+-------------+--------------+-------------------------------------------------
// in      | i_in_valid  | o_in_stall   | i_op, i_lock_index, i_sensor_levels
// out     | o_out_valid | i_out_stall  | o_drive_mask, o_light_on, o_phases,
//         |             |              | o_report_mask, o_reported_levels, o_summary_flag
// cfg     | i_cfg_we    | -            | i_cfg_index, i_cfg_data
//
// one item per cycle sustained while the result side does not stall; an item is held in the input register
// and its result is then registered in the output register.
// the lock lanes update in a single pass between the two registers.
// synchronous active-low reset; configuration returns to 20 / 300 / 3.
// a stalled result holds the output register; the input register keeps taking
// items until it is itself full behind a stalled result.

module four_lock_unlock_controller #(
    parameter int NUM_LOCKS = flc_pkg::NUM_LOCKS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input items
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_op,
    input  logic [1:0]  i_lock_index,
    input  logic [3:0]  i_sensor_levels,
    // result items
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_drive_mask,
    output logic        o_light_on,
    output logic [7:0]  o_phases,
    output logic [3:0]  o_report_mask,
    output logic [3:0]  o_reported_levels,
    output logic        o_summary_flag,
    // configuration
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [flc_pkg::CFG_W-1:0] i_cfg_data
);

    localparam int FL = flc_pkg::FIELD_LOCKS;

    logic [flc_pkg::HOLD_W-1:0]   r_hold_time;
    logic [flc_pkg::MAXOPN_W-1:0] r_max_open;
    logic [flc_pkg::FILT_W-1:0]   r_filter;

    logic       r_in_valid;
    flc_pkg::t_op r_op;
    logic [1:0] r_idx;
    logic [3:0] r_levels;

    logic       r_out_valid;
    logic       r_light, n_light;
    logic       r_summary, n_summary;
    logic [3:0] r_drive_mask, n_drive_mask;
    logic [7:0] r_phases, n_phases;
    logic [3:0] r_report_mask, n_report_mask;
    logic [3:0] r_rep_levels, n_rep_levels;

    logic w_advance;
    logic w_any_busy;
    logic w_any_pend;

    flc_pkg::t_lane_stat w_stat [NUM_LOCKS];

    // handshake
    assign w_advance  = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_advance;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_time <= flc_pkg::HOLD_TIME_RST;
            r_max_open  <= flc_pkg::MAX_OPEN_RST;
            r_filter    <= flc_pkg::FILTER_RST;
        end else if (i_cfg_we) begin
            unique case (flc_pkg::t_cfg_idx'(i_cfg_index))
                flc_pkg::CFG_HOLD_TIME: r_hold_time <= i_cfg_data[flc_pkg::HOLD_W-1:0];
                flc_pkg::CFG_MAX_OPEN:  r_max_open  <= i_cfg_data[flc_pkg::MAXOPN_W-1:0];
                flc_pkg::CFG_FILTER:    r_filter    <= i_cfg_data[flc_pkg::FILT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_op     <= flc_pkg::t_op'(i_op);
            r_idx    <= i_lock_index;
            r_levels <= i_sensor_levels;
        end
    end

    // lock lanes
    for (genvar k = 0; k < NUM_LOCKS; k++) begin : g_lane
        localparam logic [2:0] KI = 3'(k);
        flc_pkg::t_lane_cmd w_cmd;

        assign w_cmd.op  = r_op;
        assign w_cmd.sel = ({1'b0, r_idx} == KI);
        if (k < FL) begin : g_lv
            assign w_cmd.lv = r_levels[k];
        end else begin : g_nolv
            assign w_cmd.lv = 1'b0;
        end

        flc_lock u_lock (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_en        (w_advance),
            .i_cmd       (w_cmd),
            .i_hold_time (r_hold_time),
            .i_max_open  (r_max_open),
            .i_filter    (r_filter),
            .o_stat      (w_stat[k])
        );
    end

    // gather lane status into the result
    always_comb begin
        w_any_busy    = 1'b0;
        w_any_pend    = 1'b0;
        n_drive_mask  = '0;
        n_phases      = '0;
        n_report_mask = '0;
        n_rep_levels  = '0;
        for (int k = 0; k < NUM_LOCKS; k++) begin
            if (w_stat[k].phase != flc_pkg::PH_IDLE) begin
                w_any_busy = 1'b1;
            end
            if (w_stat[k].pending) begin
                w_any_pend = 1'b1;
            end
        end
        for (int b = 0; b < FL; b++) begin
            if (b < NUM_LOCKS) begin
                n_drive_mask[b]     = w_stat[b].drive;
                n_phases[2*b +: 2]  = w_stat[b].phase;
                n_report_mask[b]    = w_stat[b].pending;
                n_rep_levels[b]     = w_stat[b].level;
            end
        end
    end

    // light and summary flag
    always_comb begin
        n_light   = r_light;
        n_summary = r_summary;
        case (r_op)
            flc_pkg::OP_TICK: begin
                n_light = w_any_busy;
                if (w_any_pend) begin
                    n_summary = 1'b1;
                end
            end
            flc_pkg::OP_CLEAR: begin
                n_summary = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_light   <= 1'b0;
            r_summary <= 1'b0;
        end else if (w_advance) begin
            r_light   <= n_light;
            r_summary <= n_summary;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_drive_mask  <= n_drive_mask;
            r_phases      <= n_phases;
            r_report_mask <= n_report_mask;
            r_rep_levels  <= n_rep_levels;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_drive_mask      = r_drive_mask;
    assign o_light_on        = r_light;
    assign o_phases          = r_phases;
    assign o_report_mask     = r_report_mask;
    assign o_reported_levels = r_rep_levels;
    assign o_summary_flag    = r_summary;

endmodule

@@ test/tb_four_lock_unlock_controller.sv @@
`timescale 1ns / 1ps

module tb_four_lock_unlock_controller;

    localparam int LOCKS       = 4;
    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD   = 80;

    typedef struct packed {
        flc_pkg::t_op op;
        logic [1:0]   idx;
        logic [3:0]   levels;
    } t_lock_cmd;

    typedef struct packed {
        logic [3:0] drive_mask;
        logic       light_on;
        logic [7:0] phases;
        logic [3:0] report_mask;
        logic [3:0] reported_levels;
        logic       summary_flag;
    } t_lock_status;

    // clock, reset and block ports
    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [1:0] op_r = 2'd0;
    logic [1:0] idx_r = 2'd0;
    logic [3:0] levels_r = 4'd0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [3:0] drive_mask;
    logic       light_on;
    logic [7:0] phases;
    logic [3:0] report_mask;
    logic [3:0] reported_levels;
    logic       summary_flag;
    logic       cfg_we = 1'b0;
    logic [1:0] cfg_index = 2'd0;
    logic [flc_pkg::CFG_W-1:0] cfg_data = '0;

    // item traffic and bookkeeping
    t_lock_cmd    pending_cmds[$];
    t_lock_status expected_status[$];
    t_lock_cmd    cur_cmd = '0;
    t_lock_status want;
    int  tx_gap = 0;
    int  hold_left = 0;
    bit  tx_gaps_on = 1'b0;
    bit  rx_stall_on = 1'b0;
    bit  long_hold_req = 1'b0;
    bit  long_hold_done = 1'b0;
    int  n_errors = 0;
    int  n_results = 0;
    int  n_ops[4] = '{0, 0, 0, 0};
    int  n_settings = 1;
    int  n_opened = 0;
    int  n_closed = 0;
    int  n_expired = 0;
    int  n_reports = 0;
    int  cycles = 0;
    logic [3:0] sensor_walk = 4'd0;

    // lock controller state as the checker sees it
    flc_pkg::t_phase ph_st[LOCKS];
    bit          armed_st[LOCKS];
    logic [15:0] hold_cnt[LOCKS];
    int          open_tmr[LOCKS];
    bit          drive_st[LOCKS];
    bit          light_st;
    bit          last_lv[LOCKS];
    logic [7:0]  chg_cnt[LOCKS];
    bit          pend_st[LOCKS];
    bit          pend_lv[LOCKS];
    bit          summary_st;
    logic [flc_pkg::HOLD_W-1:0]   hold_time_q;
    logic [flc_pkg::MAXOPN_W-1:0] max_open_q;
    logic [flc_pkg::FILT_W-1:0]   filter_q;

    four_lock_unlock_controller dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .o_in_stall        (in_stall),
        .i_op              (op_r),
        .i_lock_index      (idx_r),
        .i_sensor_levels   (levels_r),
        .o_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .o_drive_mask      (drive_mask),
        .o_light_on        (light_on),
        .o_phases          (phases),
        .o_report_mask     (report_mask),
        .o_reported_levels (reported_levels),
        .o_summary_flag    (summary_flag),
        .i_cfg_we          (cfg_we),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data)
    );

    always #6 clk = ~clk;

    // one qualifying sensor reading, true once the change is confirmed
    function automatic bit confirm_level(int k);
        if (!armed_st[k]) begin
            armed_st[k] = 1'b1;
        end else begin
            hold_cnt[k] = hold_cnt[k] + 16'd1;
        end
        if (hold_cnt[k] >= hold_time_q) begin
            armed_st[k] = 1'b0;
            hold_cnt[k] = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // advance the lock state by one item and return the status it shows
    function automatic t_lock_status apply_lock_cmd(t_lock_cmd c);
        t_lock_status s;
        bit lv;
        bit any_busy;
        bit any_pend;
        s = '0;
        any_busy = 1'b0;
        any_pend = 1'b0;
        case (c.op)
            flc_pkg::OP_TICK: begin
                // phase and open timer per lock
                for (int k = 0; k < LOCKS; k++) begin
                    lv = c.levels[k];
                    if (ph_st[k] == flc_pkg::PH_UNLOCKING) begin
                        if (!lv) begin
                            if (confirm_level(k)) begin
                                drive_st[k] = 1'b0;
                                ph_st[k] = flc_pkg::PH_OPEN;
                                n_opened++;
                            end
                        end
                    end else if (ph_st[k] == flc_pkg::PH_OPEN) begin
                        if (lv) begin
                            if (confirm_level(k)) begin
                                drive_st[k] = 1'b0;
                                ph_st[k] = flc_pkg::PH_IDLE;
                                n_closed++;
                            end
                        end
                    end else begin
                        ph_st[k] = flc_pkg::PH_IDLE;
                        armed_st[k] = 1'b0;
                        hold_cnt[k] = '0;
                    end
                    if (ph_st[k] != flc_pkg::PH_IDLE) begin
                        open_tmr[k] = open_tmr[k] - 1;
                        if (open_tmr[k] <= 0) begin
                            drive_st[k] = 1'b0;
                            open_tmr[k] = int'(max_open_q);
                            n_expired++;
                        end
                        any_busy = 1'b1;
                    end
                end
                light_st = any_busy;
                // change filter and reports
                for (int k = 0; k < LOCKS; k++) begin
                    lv = c.levels[k];
                    if (!pend_st[k]) begin
                        if (last_lv[k] != lv) begin
                            chg_cnt[k] = chg_cnt[k] + 8'd1;
                            if (chg_cnt[k] >= filter_q) begin
                                pend_st[k] = 1'b1;
                                pend_lv[k] = lv;
                                chg_cnt[k] = '0;
                                last_lv[k] = lv;
                                n_reports++;
                            end
                        end else begin
                            chg_cnt[k] = '0;
                        end
                    end
                    if (pend_st[k]) any_pend = 1'b1;
                end
                if (any_pend) summary_st = 1'b1;
            end
            flc_pkg::OP_UNLOCK: begin
                ph_st[c.idx] = flc_pkg::PH_UNLOCKING;
                drive_st[c.idx] = 1'b1;
            end
            flc_pkg::OP_ACK: begin
                pend_st[c.idx] = 1'b0;
            end
            default: begin
                summary_st = 1'b0;
            end
        endcase
        for (int k = 0; k < LOCKS; k++) begin
            s.drive_mask[k] = drive_st[k];
            s.phases[2*k +: 2] = ph_st[k];
            s.report_mask[k] = pend_st[k];
            s.reported_levels[k] = pend_lv[k];
        end
        s.light_on = light_st;
        s.summary_flag = summary_st;
        return s;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    task automatic report_error(input string msg);
        n_errors++;
        $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] exp_v);
        if (got !== exp_v)
            report_error($sformatf("result %0d %s: got %0h, expected %0h",
                                   n_results, name, got, exp_v));
    endtask

    // item driver: predicts each accepted item, then offers the next one
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                expected_status.push_back(apply_lock_cmd(cur_cmd));
                n_ops[cur_cmd.op]++;
            end
            if (!in_valid || !in_stall) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    in_valid <= 1'b0;
                end else if (pending_cmds.size() != 0) begin
                    cur_cmd = pending_cmds.pop_front();
                    op_r <= cur_cmd.op;
                    idx_r <= cur_cmd.idx;
                    levels_r <= cur_cmd.levels;
                    in_valid <= 1'b1;
                    tx_gap = tx_gaps_on ? pick_gap() : 0;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result side stall, with one long hold-off when asked
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else if (long_hold_req && !long_hold_done) begin
            long_hold_done = 1'b1;
            hold_left = LONG_HOLD - 1;
            out_stall <= 1'b1;
        end else if (rx_stall_on) begin
            hold_left = pick_gap();
            out_stall <= (hold_left != 0);
            if (hold_left != 0) hold_left--;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // result monitor
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (expected_status.size() == 0) begin
                report_error($sformatf("result with nothing expected, phases %h", phases));
            end else begin
                want = expected_status.pop_front();
                n_results++;
                check_field("drive_mask", 8'(drive_mask), 8'(want.drive_mask));
                check_field("light_on", 8'(light_on), 8'(want.light_on));
                check_field("phases", phases, want.phases);
                check_field("report_mask", 8'(report_mask), 8'(want.report_mask));
                check_field("reported_levels", 8'(reported_levels),
                            8'(want.reported_levels));
                check_field("summary_flag", 8'(summary_flag), 8'(want.summary_flag));
            end
        end
    end

    // run watchdog
    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, expected_status.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic wait_idle();
        do @(posedge clk);
        while (pending_cmds.size() != 0 || in_valid || expected_status.size() != 0);
    endtask

    task automatic write_reg(input flc_pkg::t_cfg_idx idx, input logic [15:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            flc_pkg::CFG_HOLD_TIME: hold_time_q = data;
            flc_pkg::CFG_MAX_OPEN:  max_open_q = data[flc_pkg::MAXOPN_W-1:0];
            flc_pkg::CFG_FILTER:    filter_q = data[flc_pkg::FILT_W-1:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic queue_cmd(input flc_pkg::t_op op, input logic [1:0] idx,
                             input logic [3:0] lv);
        t_lock_cmd c;
        c.op = op;
        c.idx = idx;
        c.levels = lv;
        pending_cmds.push_back(c);
    endtask

    // one register setting followed by random items
    task automatic run_phase(input logic [15:0] h, input logic [15:0] m, input logic [15:0] f,
                             input int n, input bit noise, input bit gaps, input bit stalls,
                             input bit hold_off);
        t_lock_cmd c;
        int r;
        wait_idle();
        write_reg(flc_pkg::CFG_HOLD_TIME, h);
        write_reg(flc_pkg::CFG_MAX_OPEN, m);
        write_reg(flc_pkg::CFG_FILTER, f);
        n_settings++;
        tx_gaps_on = gaps;
        rx_stall_on = stalls;
        repeat (n) begin
            r = $urandom_range(99);
            c.op = (r < 68) ? flc_pkg::OP_TICK :
                   (r < 82) ? flc_pkg::OP_UNLOCK :
                   (r < 92) ? flc_pkg::OP_ACK : flc_pkg::OP_CLEAR;
            c.idx = 2'($urandom_range(3));
            if (c.op != flc_pkg::OP_TICK || noise) begin
                c.levels = 4'($urandom_range(15));
            end else begin
                // sensors mostly hold their level so confirms and filters complete
                for (int k = 0; k < LOCKS; k++)
                    if ($urandom_range(7) == 0) sensor_walk[k] = ~sensor_walk[k];
                c.levels = sensor_walk;
            end
            pending_cmds.push_back(c);
        end
        if (hold_off) long_hold_req = 1'b1;
        wait_idle();
    endtask

    initial begin
        // state after reset
        hold_time_q = flc_pkg::HOLD_TIME_RST;
        max_open_q = flc_pkg::MAX_OPEN_RST;
        filter_q = flc_pkg::FILTER_RST;
        for (int k = 0; k < LOCKS; k++) begin
            ph_st[k] = flc_pkg::PH_IDLE;
            armed_st[k] = 1'b0;
            hold_cnt[k] = '0;
            open_tmr[k] = int'(flc_pkg::MAX_OPEN_RST);
            drive_st[k] = 1'b0;
            last_lv[k] = 1'b0;
            chg_cnt[k] = '0;
            pend_st[k] = 1'b0;
            pend_lv[k] = 1'b0;
        end
        light_st = 1'b0;
        summary_st = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed items at the reset setting
        tx_gaps_on = 1'b1;
        rx_stall_on = 1'b1;
        queue_cmd(flc_pkg::OP_UNLOCK, 2'd0, 4'hF);
        queue_cmd(flc_pkg::OP_UNLOCK, 2'd1, 4'h0);
        queue_cmd(flc_pkg::OP_UNLOCK, 2'd2, 4'hA);
        queue_cmd(flc_pkg::OP_UNLOCK, 2'd3, 4'h5);
        queue_cmd(flc_pkg::OP_TICK, 2'd0, 4'h0);
        queue_cmd(flc_pkg::OP_TICK, 2'd3, 4'h0);
        queue_cmd(flc_pkg::OP_TICK, 2'd0, 4'hF);
        queue_cmd(flc_pkg::OP_TICK, 2'd1, 4'hF);
        queue_cmd(flc_pkg::OP_TICK, 2'd2, 4'hF);
        // clear while reports are pending, then the next tick sets it again
        queue_cmd(flc_pkg::OP_CLEAR, 2'd3, 4'hF);
        queue_cmd(flc_pkg::OP_TICK, 2'd0, 4'hF);
        queue_cmd(flc_pkg::OP_ACK, 2'd0, 4'h1);
        queue_cmd(flc_pkg::OP_ACK, 2'd1, 4'h2);
        queue_cmd(flc_pkg::OP_ACK, 2'd2, 4'h4);
        queue_cmd(flc_pkg::OP_ACK, 2'd3, 4'h8);
        queue_cmd(flc_pkg::OP_CLEAR, 2'd0, 4'h0);
        queue_cmd(flc_pkg::OP_TICK, 2'd0, 4'h5);
        queue_cmd(flc_pkg::OP_TICK, 2'd0, 4'hA);
        // unlock of a lock that is already busy
        queue_cmd(flc_pkg::OP_UNLOCK, 2'd2, 4'h0);
        queue_cmd(flc_pkg::OP_TICK, 2'd1, 4'h0);
        queue_cmd(flc_pkg::OP_TICK, 2'd2, 4'h0);
        queue_cmd(flc_pkg::OP_TICK, 2'd3, 4'hF);
        wait_idle();

        // random phases over several settings
        run_phase(16'd2, 16'd40, 16'd2, 150, 1'b0, 1'b1, 1'b1, 1'b0);
        run_phase(16'd0, 16'd0, 16'd0, 100, 1'b0, 1'b0, 1'b0, 1'b0);
        run_phase(16'd3, 16'd12, 16'd1, 100, 1'b0, 1'b0, 1'b1, 1'b1);
        write_reg(flc_pkg::CFG_NONE, 16'($urandom));
        run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 60, 1'b0, 1'b1, 1'b1, 1'b0);
        // lowered limits right after the widest ones
        run_phase(16'd1, 16'd5, 16'd1, 150, 1'b0, 1'b1, 1'b1, 1'b0);
        run_phase(16'd5, 16'd50, 16'd4, 140, 1'b1, 1'b1, 1'b1, 1'b0);
        run_phase(16'd9, 16'h8007, 16'h0106, 60, 1'b0, 1'b1, 1'b0, 1'b0);

        // drain and let the pipeline settle
        wait_idle();
        repeat (4) @(posedge clk);
        if (expected_status.size() != 0)
            report_error($sformatf("%0d results never arrived", expected_status.size()));
        $display("covered %0d items (%0d ticks, %0d unlocks, %0d acks, %0d clears), %0d settings",
                 n_ops.sum(), n_ops[flc_pkg::OP_TICK], n_ops[flc_pkg::OP_UNLOCK],
                 n_ops[flc_pkg::OP_ACK], n_ops[flc_pkg::OP_CLEAR], n_settings);
        $display("%0d results checked: %0d opened, %0d reclosed, %0d timer expiries, %0d reports",
                 n_results, n_opened, n_closed, n_expired, n_reports);
        if (n_errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
